// File: design/stereo_reverb_engine_unit_macros.svh
// Assertion macros used by the checker file srev_chk.sv.
`ifndef STEREO_REVERB_ENGINE_UNIT_MACROS_SVH
`define STEREO_REVERB_ENGINE_UNIT_MACROS_SVH

// Next-cycle implication, disabled while reset is held.
`define SRV_ASSERT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("stereo reverb check failed");

// Next-cycle implication that is also checked across reset.
`define SRV_ASSERT_RST(lbl, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("stereo reverb reset check failed");

`endif

// File: design/srev_pkg.sv
`default_nettype none
package srev_pkg;

  localparam int RAM_BYTES_DEF = 524288;
  localparam int NUM_WORDS     = 35;
  localparam int ACW           = 24;
  localparam int PROG_LEN      = 68;
  localparam int PCW           = $clog2(PROG_LEN);
  localparam logic [5:0] REG_BASE = 6'd32;

  typedef struct packed {
    logic               operation;
    logic        [5:0]  reg_index;
    logic        [15:0] reg_value;
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
  } out_item_t;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_RUN} st_t;
  typedef enum logic [2:0] {PH_RDA, PH_RDB, PH_GO, PH_WAIT, PH_LAND} ph_t;
  typedef enum logic [2:0] {K_ALU, K_RD, K_WR, K_POS, K_OUT} kind_t;
  typedef enum logic [1:0] {A_OFF, A_OFF_M1, A_OFF_MD, A_STEP} adj_t;
  typedef enum logic [1:0] {B_ZERO, B_ACC, B_XL, B_XR} base_t;
  typedef enum logic [2:0] {M_MD, M_ACC, M_INL, M_INR, M_SAT} msrc_t;
  typedef enum logic [1:0] {P_NONE, P_ADD, P_SUB} prod_t;
  typedef enum logic [2:0] {D_NONE, D_PADD, D_PSUB, D_LIN, D_RIN, D_MD} addn_t;
  typedef enum logic [3:0] {
    R_ACC, R_LIN, R_RIN, R_XL, R_XR, R_OL, R_OR, R_P, R_MD
  } dst_t;

  typedef struct packed {
    kind_t      kind;
    adj_t       adj;
    logic [5:0] oa;
    logic [5:0] od;
    base_t      base;
    msrc_t      msrc;
    prod_t      prod;
    logic [5:0] gidx;
    addn_t      addn;
    dst_t       dst;
  } uword_t;

  typedef struct packed {
    uword_t     uw;
    logic [5:0] widx;
    logic       wa_cap;
    logic       mod_start;
    logic       alu_en;
    logic       rd_en;
    logic       land_en;
    logic       wr_en;
    logic       pos_en;
    logic       out_load;
    logic       in_cap;
    logic       cfg_we;
  } dp_ctl_t;

  function automatic logic signed [15:0] sat16(input logic signed [ACW-1:0] v);
    logic signed [15:0] r;
    if (v > ACW'(32767)) r = 16'sh7fff;
    else if (v < -ACW'(32768)) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic uword_t ua(input base_t b, input msrc_t m, input prod_t p,
                                input logic [5:0] g, input addn_t a, input dst_t d);
    uword_t w;
    w = '0;
    w.kind = K_ALU; w.base = b; w.msrc = m; w.prod = p;
    w.gidx = g; w.addn = a; w.dst = d;
    return w;
  endfunction

  function automatic uword_t um(input kind_t k, input adj_t j, input logic [5:0] oa,
                                input logic [5:0] od, input dst_t d);
    uword_t w;
    w = '0;
    w.kind = k; w.adj = j; w.oa = oa; w.od = od; w.dst = d;
    return w;
  endfunction

  function automatic uword_t uc(input kind_t k);
    uword_t w;
    w = '0;
    w.kind = k; w.adj = A_STEP;
    return w;
  endfunction

  function automatic uword_t uc_rom(input logic [PCW-1:0] pc);
    uword_t w;
    case (pc)
      7'd0:  w = ua(B_ZERO, M_INL, P_ADD, 6'd30, D_NONE, R_LIN);
      7'd1:  w = ua(B_ZERO, M_INR, P_ADD, 6'd31, D_NONE, R_RIN);
      7'd2:  w = um(K_RD, A_OFF_M1, 6'd10, 6'd0, R_P);
      7'd3:  w = um(K_RD, A_OFF, 6'd16, 6'd0, R_MD);
      7'd4:  w = ua(B_ZERO, M_MD, P_ADD, 6'd7, D_LIN, R_ACC);
      7'd5:  w = ua(B_ACC, M_MD, P_NONE, 6'd0, D_PSUB, R_ACC);
      7'd6:  w = ua(B_ZERO, M_ACC, P_ADD, 6'd2, D_PADD, R_ACC);
      7'd7:  w = um(K_WR, A_OFF, 6'd10, 6'd0, R_ACC);
      7'd8:  w = um(K_RD, A_OFF_M1, 6'd11, 6'd0, R_P);
      7'd9:  w = um(K_RD, A_OFF, 6'd17, 6'd0, R_MD);
      7'd10: w = ua(B_ZERO, M_MD, P_ADD, 6'd7, D_RIN, R_ACC);
      7'd11: w = ua(B_ACC, M_MD, P_NONE, 6'd0, D_PSUB, R_ACC);
      7'd12: w = ua(B_ZERO, M_ACC, P_ADD, 6'd2, D_PADD, R_ACC);
      7'd13: w = um(K_WR, A_OFF, 6'd11, 6'd0, R_ACC);
      7'd14: w = um(K_RD, A_OFF_M1, 6'd18, 6'd0, R_P);
      7'd15: w = um(K_RD, A_OFF, 6'd25, 6'd0, R_MD);
      7'd16: w = ua(B_ZERO, M_MD, P_ADD, 6'd7, D_LIN, R_ACC);
      7'd17: w = ua(B_ACC, M_MD, P_NONE, 6'd0, D_PSUB, R_ACC);
      7'd18: w = ua(B_ZERO, M_ACC, P_ADD, 6'd2, D_PADD, R_ACC);
      7'd19: w = um(K_WR, A_OFF, 6'd18, 6'd0, R_ACC);
      7'd20: w = um(K_RD, A_OFF_M1, 6'd19, 6'd0, R_P);
      7'd21: w = um(K_RD, A_OFF, 6'd24, 6'd0, R_MD);
      7'd22: w = ua(B_ZERO, M_MD, P_ADD, 6'd7, D_RIN, R_ACC);
      7'd23: w = ua(B_ACC, M_MD, P_NONE, 6'd0, D_PSUB, R_ACC);
      7'd24: w = ua(B_ZERO, M_ACC, P_ADD, 6'd2, D_PADD, R_ACC);
      7'd25: w = um(K_WR, A_OFF, 6'd19, 6'd0, R_ACC);
      7'd26: w = um(K_RD, A_OFF, 6'd12, 6'd0, R_MD);
      7'd27: w = ua(B_ZERO, M_MD, P_ADD, 6'd3, D_NONE, R_ACC);
      7'd28: w = um(K_RD, A_OFF, 6'd14, 6'd0, R_MD);
      7'd29: w = ua(B_ACC, M_MD, P_ADD, 6'd4, D_NONE, R_ACC);
      7'd30: w = um(K_RD, A_OFF, 6'd20, 6'd0, R_MD);
      7'd31: w = ua(B_ACC, M_MD, P_ADD, 6'd5, D_NONE, R_ACC);
      7'd32: w = um(K_RD, A_OFF, 6'd22, 6'd0, R_MD);
      7'd33: w = ua(B_ACC, M_MD, P_ADD, 6'd6, D_NONE, R_XL);
      7'd34: w = um(K_RD, A_OFF, 6'd13, 6'd0, R_MD);
      7'd35: w = ua(B_ZERO, M_MD, P_ADD, 6'd3, D_NONE, R_ACC);
      7'd36: w = um(K_RD, A_OFF, 6'd15, 6'd0, R_MD);
      7'd37: w = ua(B_ACC, M_MD, P_ADD, 6'd4, D_NONE, R_ACC);
      7'd38: w = um(K_RD, A_OFF, 6'd21, 6'd0, R_MD);
      7'd39: w = ua(B_ACC, M_MD, P_ADD, 6'd5, D_NONE, R_ACC);
      7'd40: w = um(K_RD, A_OFF, 6'd23, 6'd0, R_MD);
      7'd41: w = ua(B_ACC, M_MD, P_ADD, 6'd6, D_NONE, R_XR);
      7'd42: w = um(K_RD, A_OFF_MD, 6'd26, 6'd0, R_MD);
      7'd43: w = ua(B_XL, M_MD, P_SUB, 6'd8, D_NONE, R_ACC);
      7'd44: w = um(K_WR, A_OFF, 6'd26, 6'd0, R_ACC);
      7'd45: w = um(K_RD, A_OFF_MD, 6'd26, 6'd0, R_MD);
      7'd46: w = ua(B_ZERO, M_ACC, P_ADD, 6'd8, D_MD, R_XL);
      7'd47: w = um(K_RD, A_OFF_MD, 6'd27, 6'd0, R_MD);
      7'd48: w = ua(B_XR, M_MD, P_SUB, 6'd8, D_NONE, R_ACC);
      7'd49: w = um(K_WR, A_OFF, 6'd27, 6'd0, R_ACC);
      7'd50: w = um(K_RD, A_OFF_MD, 6'd27, 6'd0, R_MD);
      7'd51: w = ua(B_ZERO, M_ACC, P_ADD, 6'd8, D_MD, R_XR);
      7'd52: w = um(K_RD, A_OFF_MD, 6'd28, 6'd1, R_MD);
      7'd53: w = ua(B_XL, M_MD, P_SUB, 6'd9, D_NONE, R_ACC);
      7'd54: w = um(K_WR, A_OFF, 6'd28, 6'd0, R_ACC);
      7'd55: w = um(K_RD, A_OFF_MD, 6'd28, 6'd1, R_MD);
      7'd56: w = ua(B_ZERO, M_ACC, P_ADD, 6'd9, D_MD, R_XL);
      7'd57: w = um(K_RD, A_OFF_MD, 6'd29, 6'd1, R_MD);
      7'd58: w = ua(B_XR, M_MD, P_SUB, 6'd9, D_NONE, R_ACC);
      7'd59: w = um(K_WR, A_OFF, 6'd29, 6'd0, R_ACC);
      7'd60: w = um(K_RD, A_OFF_MD, 6'd29, 6'd1, R_MD);
      7'd61: w = ua(B_ZERO, M_ACC, P_ADD, 6'd9, D_MD, R_XR);
      7'd62: w = ua(B_XL, M_MD, P_NONE, 6'd0, D_NONE, R_ACC);
      7'd63: w = ua(B_ZERO, M_SAT, P_ADD, 6'd33, D_NONE, R_OL);
      7'd64: w = ua(B_XR, M_MD, P_NONE, 6'd0, D_NONE, R_ACC);
      7'd65: w = ua(B_ZERO, M_SAT, P_ADD, 6'd34, D_NONE, R_OR);
      7'd66: w = uc(K_POS);
      7'd67: w = uc(K_OUT);
      default: w = uc(K_OUT);
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// File: design/srev_mod.sv
`default_nettype none
module srev_mod #(
  parameter int RAM_BYTES = srev_pkg::RAM_BYTES_DEF,
  localparam int RW = RAM_BYTES / 2,
  localparam int AW = $clog2(RW),
  localparam int SW = ((AW > 18) ? AW : 18) + 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [SW-1:0] s,
  input  logic        [AW:0]   n,
  output logic        [AW-1:0] r,
  output logic                 done
);
  import srev_pkg::*;

  localparam int MW = SW - 1;
  localparam int CW = $clog2(MW + 1);

  logic          busy_r, done_r, neg_r;
  logic [CW-1:0] cnt_r;
  logic [MW-1:0] mag_r;
  logic [AW-1:0] rem_r, r_r;
  logic [AW:0]   rem_sh;
  logic [AW-1:0] rem_nxt;
  logic [SW-1:0] s_abs;

  assign s_abs   = s[SW-1] ? SW'(-s) : SW'(s);
  assign rem_sh  = {rem_r, mag_r[MW-1]};
  assign rem_nxt = (rem_sh >= n) ? AW'(rem_sh - n) : rem_sh[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(MW);
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end else begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= s[SW-1];
      mag_r <= s_abs[MW-1:0];
      rem_r <= '0;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        rem_r <= rem_nxt;
        mag_r <= {mag_r[MW-2:0], 1'b0};
      end else begin
        r_r <= (neg_r && rem_r != '0) ? AW'(n - {1'b0, rem_r}) : rem_r;
      end
    end
  end

  assign r    = r_r;
  assign done = done_r;

endmodule
`default_nettype wire

// File: design/srev_seq.sv
`default_nettype none
module srev_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_op,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  logic              clr_done,
  input  logic              mod_done,
  output srev_pkg::dp_ctl_t ctl
);
  import srev_pkg::*;

  st_t            state_r, state_nxt;
  ph_t            ph_r, ph_nxt;
  logic [PCW-1:0] pc_r, pc_nxt;
  logic           out_valid_r, out_valid_nxt;
  uword_t         uw;

  assign uw = uc_rom(pc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      ph_r        <= PH_RDA;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    pc_nxt    = pc_r;
    in_ready  = 1'b0;
    ctl       = '0;
    ctl.uw    = uw;
    ctl.widx  = uw.gidx;
    case (state_r)
      ST_CLEAR: begin
        if (clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op) begin
            ctl.cfg_we = 1'b1;
          end else begin
            ctl.in_cap = 1'b1;
            pc_nxt     = '0;
            ph_nxt     = PH_RDA;
            state_nxt  = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        case (uw.kind)
          K_ALU: begin
            if (ph_r == PH_RDA) begin
              ph_nxt = PH_RDB;
            end else begin
              ctl.alu_en = 1'b1;
              pc_nxt     = pc_r + 1'b1;
              ph_nxt     = PH_RDA;
            end
          end
          K_RD, K_WR: begin
            case (ph_r)
              PH_RDA: begin
                ctl.widx = uw.oa;
                ph_nxt   = PH_RDB;
              end
              PH_RDB: begin
                ctl.widx   = uw.od;
                ctl.wa_cap = 1'b1;
                ph_nxt     = PH_GO;
              end
              PH_GO: begin
                ctl.mod_start = 1'b1;
                ph_nxt        = PH_WAIT;
              end
              PH_WAIT: begin
                if (mod_done) begin
                  if (uw.kind == K_RD) begin
                    ctl.rd_en = 1'b1;
                    ph_nxt    = PH_LAND;
                  end else begin
                    ctl.wr_en = 1'b1;
                    pc_nxt    = pc_r + 1'b1;
                    ph_nxt    = PH_RDA;
                  end
                end
              end
              PH_LAND: begin
                ctl.land_en = 1'b1;
                pc_nxt      = pc_r + 1'b1;
                ph_nxt      = PH_RDA;
              end
              default: ph_nxt = PH_RDA;
            endcase
          end
          K_POS: begin
            if (ph_r == PH_WAIT) begin
              if (mod_done) begin
                ctl.pos_en = 1'b1;
                pc_nxt     = pc_r + 1'b1;
                ph_nxt     = PH_RDA;
              end
            end else begin
              ctl.mod_start = 1'b1;
              ph_nxt        = PH_WAIT;
            end
          end
          K_OUT: begin
            if (!out_valid_r || out_ready) begin
              ctl.out_load = 1'b1;
              state_nxt    = ST_IDLE;
            end
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      default: state_nxt = ST_CLEAR;
    endcase
    out_valid_nxt = ctl.out_load | (out_valid_r & ~out_ready);
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// File: design/srev_dp.sv
`default_nettype none
module srev_dp #(
  parameter int RAM_BYTES = srev_pkg::RAM_BYTES_DEF,
  localparam int RW = RAM_BYTES / 2,
  localparam int AW = $clog2(RW),
  localparam int SW = ((AW > 18) ? AW : 18) + 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  srev_pkg::dp_ctl_t    ctl,
  input  srev_pkg::in_item_t   in_data,
  output logic                 clr_done,
  output logic signed [SW-1:0] mod_s,
  output logic        [AW:0]   mod_n,
  input  logic        [AW-1:0] mod_r,
  output srev_pkg::out_item_t  out_data
);
  import srev_pkg::*;

  localparam int PW = ACW + 16;

  logic        [15:0]    w_r [NUM_WORDS];
  logic        [15:0]    wq_r, wa_r, base_r;
  logic        [15:0]    mem_r [RW];
  logic        [15:0]    ram_q_r;
  logic        [AW:0]    clr_cnt_r;
  logic                  clearing;
  logic        [AW-1:0]  pos_r, base_eff, ram_addr;
  logic        [18:0]    b4;
  logic signed [SW-1:0]  wa4, wb4, d;
  logic signed [ACW-1:0] acc_r, xl_r, xr_r;
  logic signed [16:0]    lin_r, rin_r;
  logic signed [15:0]    p_r, md_r, inl_r, inr_r, oleft_r, oright_r;
  out_item_t             out_r;
  logic signed [ACW-1:0] base_v, ma, addv, prod_q, res;
  logic signed [15:0]    g;
  logic signed [PW-1:0]  prod_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (ctl.cfg_we && in_data.reg_index < 6'(NUM_WORDS)) begin
      if (in_data.reg_index == REG_BASE) base_r <= in_data.reg_value;
    end
  end

  // The reverb words are cleared during the same pass that clears sound RAM.
  always_ff @(posedge clk) begin
    if (clearing && clr_cnt_r < (AW+1)'(NUM_WORDS)) begin
      w_r[clr_cnt_r[5:0]] <= '0;
    end else if (ctl.cfg_we && in_data.reg_index < 6'(NUM_WORDS)) begin
      w_r[in_data.reg_index] <= in_data.reg_value;
    end
  end

  always_ff @(posedge clk) begin
    wq_r <= w_r[ctl.widx];
    if (ctl.wa_cap) wa_r <= wq_r;
  end

  assign b4       = {1'b0, base_r, 2'b00};
  assign base_eff = (b4 >= 19'(RW)) ? '0 : b4[AW-1:0];
  assign mod_n    = (AW+1)'(RW) - {1'b0, base_eff};
  assign wa4      = signed'({{(SW-18){1'b0}}, wa_r, 2'b00});
  assign wb4      = signed'({{(SW-18){1'b0}}, wq_r, 2'b00});

  always_comb begin
    case (ctl.uw.adj)
      A_OFF:    d = wa4;
      A_OFF_M1: d = wa4 - SW'(1);
      A_OFF_MD: d = wa4 - wb4;
      A_STEP:   d = SW'(1);
      default:  d = '0;
    endcase
  end

  assign mod_s    = signed'({{(SW-AW){1'b0}}, pos_r}) + d;
  assign ram_addr = base_eff + mod_r;

  assign clearing = (clr_cnt_r != (AW+1)'(RW));
  assign clr_done = ~clearing;

  always_ff @(posedge clk) begin
    if (!rst_n) clr_cnt_r <= '0;
    else if (clearing) clr_cnt_r <= clr_cnt_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (clearing) mem_r[clr_cnt_r[AW-1:0]] <= '0;
    else if (ctl.wr_en) mem_r[ram_addr] <= sat16(acc_r);
    if (ctl.rd_en) ram_q_r <= mem_r[ram_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pos_r <= '0;
    else if (ctl.pos_en) pos_r <= mod_r;
  end

  assign g = wq_r;

  always_comb begin
    case (ctl.uw.base)
      B_ZERO:  base_v = '0;
      B_ACC:   base_v = acc_r;
      B_XL:    base_v = xl_r;
      B_XR:    base_v = xr_r;
      default: base_v = '0;
    endcase
    case (ctl.uw.msrc)
      M_MD:    ma = ACW'(md_r);
      M_ACC:   ma = acc_r;
      M_INL:   ma = ACW'(inl_r);
      M_INR:   ma = ACW'(inr_r);
      M_SAT:   ma = ACW'(sat16(acc_r));
      default: ma = '0;
    endcase
    case (ctl.uw.addn)
      D_NONE:  addv = '0;
      D_PADD:  addv = ACW'(p_r);
      D_PSUB:  addv = -ACW'(p_r);
      D_LIN:   addv = ACW'(lin_r);
      D_RIN:   addv = ACW'(rin_r);
      D_MD:    addv = ACW'(md_r);
      default: addv = '0;
    endcase
    prod_full = PW'(ma) * PW'(g);
    prod_q    = prod_full[ACW+14:15];
    case (ctl.uw.prod)
      P_NONE:  res = base_v + addv;
      P_ADD:   res = base_v + prod_q + addv;
      P_SUB:   res = base_v - prod_q + addv;
      default: res = base_v + addv;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.in_cap) begin
      inl_r <= in_data.left_in;
      inr_r <= in_data.right_in;
    end
    if (ctl.alu_en) begin
      case (ctl.uw.dst)
        R_ACC:   acc_r    <= res;
        R_LIN:   lin_r    <= res[16:0];
        R_RIN:   rin_r    <= res[16:0];
        R_XL:    xl_r     <= res;
        R_XR:    xr_r     <= res;
        R_OL:    oleft_r  <= sat16(res);
        R_OR:    oright_r <= sat16(res);
        default: acc_r    <= res;
      endcase
    end
    if (ctl.land_en) begin
      case (ctl.uw.dst)
        R_P:     p_r  <= ram_q_r;
        default: md_r <= ram_q_r;
      endcase
    end
    if (ctl.out_load) begin
      out_r.left_out  <= oleft_r;
      out_r.right_out <= oright_r;
    end
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

// File: design/stereo_reverb_engine_unit.sv
// Stereo reverb over a circular work area in sound RAM, driven by a small
// microcode program. A register write request (operation high) stores one of
// 35 reverb words and returns nothing. A sample request runs a 68-step
// program that issues 32 sound RAM accesses on one port plus one position
// update; the address of each access is reduced modulo the work area by a
// one-bit-per-cycle remainder unit. A finished result waits in an output
// register, and a new request is taken while it waits. After reset the block
// clears sound RAM and the reverb words one word per cycle, and holds
// in_ready low until the clear is finished.
`default_nettype none
module stereo_reverb_engine_unit #(
  parameter int RAM_BYTES = srev_pkg::RAM_BYTES_DEF,
  localparam int RW = RAM_BYTES / 2,
  localparam int AW = $clog2(RW),
  localparam int SW = ((AW > 18) ? AW : 18) + 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  srev_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output srev_pkg::out_item_t out_data
);
  import srev_pkg::*;

  dp_ctl_t              ctl;
  logic                 clr_done, mod_done;
  logic signed [SW-1:0] mod_s;
  logic        [AW:0]   mod_n;
  logic        [AW-1:0] mod_r;

  srev_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.operation),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .clr_done  (clr_done),
    .mod_done  (mod_done),
    .ctl       (ctl)
  );

  srev_dp #(.RAM_BYTES(RAM_BYTES)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .in_data  (in_data),
    .clr_done (clr_done),
    .mod_s    (mod_s),
    .mod_n    (mod_n),
    .mod_r    (mod_r),
    .out_data (out_data)
  );

  srev_mod #(.RAM_BYTES(RAM_BYTES)) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.mod_start),
    .s     (mod_s),
    .n     (mod_n),
    .r     (mod_r),
    .done  (mod_done)
  );

endmodule
`default_nettype wire

// File: design/srev_chk.sv
`default_nettype none
`include "stereo_reverb_engine_unit_macros.svh"
module srev_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input srev_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input srev_pkg::out_item_t out_data
);

  `SRV_ASSERT_RST(a_reset_quiet, !rst_n, !in_ready && !out_valid)
  `SRV_ASSERT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `SRV_ASSERT(a_write_no_result, in_valid && in_ready && in_data.operation && !out_valid, !out_valid)
  `SRV_ASSERT(a_sample_busy, in_valid && in_ready && !in_data.operation, !in_ready)

endmodule

bind stereo_reverb_engine_unit srev_chk u_chk (.*);
`default_nettype wire
